FILE: src/jsw_pkg.sv
// Package for the Jacobi symbol word unit: transaction payload types,
// controller-to-datapath command and status structs, and width constants.
// No dependencies.
`default_nettype none

package jsw_pkg;

  // Default and maximum word width of the operands.
  localparam int unsigned WordBitsDef = 64;
  localparam int unsigned FieldBits   = 64;

  // Request transaction: the two operands of the symbol.
  typedef struct packed {
    logic [FieldBits-1:0] numerator;
    logic [FieldBits-1:0] modulus;
  } jsw_req_t;

  // Response transaction: the symbol in two's complement and the error flag.
  typedef struct packed {
    logic signed [1:0] symbol;
    logic              even_modulus;
  } jsw_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Capture the operands and set up the first reduction.
    logic div_step;    // One restoring shift-and-subtract step.
    logic div_done;    // Move the remainder into the numerator register.
    logic strip_shift; // Remove one factor of two from the numerator.
    logic strip_end;   // Apply the sign rules and set up the next reduction.
  } jsw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last; // The current division step is the final one.
    logic a_zero;   // Numerator register is zero.
    logic a_even;   // Numerator register is even.
    logic a_one;    // Numerator register is one.
  } jsw_sts_t;

endpackage : jsw_pkg

`default_nettype wire

FILE: src/jacobi_symbol_word_unit.sv
// Jacobi symbol word unit: top level joining controller and datapath.
// For an even modulus the result strobe follows in the cycle after acceptance.
// Otherwise each remainder step, the first reduction included, runs the
// bit-serial divider over every dividend bit, moves the remainder into the
// numerator register and removes its factors of two one at a time. A new
// transaction is accepted in the strobe cycle; the result strobe cannot be stalled.
// Asynchronous active-low reset returns the unit to idle.
`default_nettype none

module jacobi_symbol_word_unit #(
  parameter int unsigned WORD_BITS = jsw_pkg::WordBitsDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  jsw_pkg::jsw_req_t req_i,
  output logic              done_o,
  output jsw_pkg::jsw_rsp_t rsp_o
);
  import jsw_pkg::*;

  jsw_cmd_t cmd;
  jsw_sts_t sts;

  // Sequencing of the reduction and sign steps.
  jsw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .modulus_odd_i (req_i.modulus[0]),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .done_o        (done_o)
  );

  // Operand registers, remainder unit and result formation.
  jsw_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule : jacobi_symbol_word_unit

`default_nettype wire

FILE: src/jsw_datapath.sv
// Datapath of the Jacobi symbol word unit: operand registers, a bit-serial
// restoring remainder unit and the sign logic. Depends on jsw_pkg.
`default_nettype none

module jsw_datapath #(
  parameter int unsigned WORD_BITS = jsw_pkg::WordBitsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  jsw_pkg::jsw_req_t req_i,
  input  jsw_pkg::jsw_cmd_t cmd_i,
  output jsw_pkg::jsw_sts_t sts_o,
  output jsw_pkg::jsw_rsp_t rsp_o
);
  import jsw_pkg::*;

  localparam int unsigned CntBits = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CntBits-1:0] CntLast = CntBits'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] m_q, m_d;
  logic [WORD_BITS-1:0] dvd_q, dvd_d;
  logic [WORD_BITS:0]   rem_q, rem_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 odd_q, odd_d;
  logic                 neg_q, neg_d;
  logic                 even_q, even_d;

  logic [WORD_BITS:0]   rem_shift;
  logic [WORD_BITS:0]   rem_sub;
  logic                 rem_ge;
  logic                 flip_two;
  logic                 flip_recip;

  // Restoring division: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    rem_shift = {rem_q[WORD_BITS-1:0], dvd_q[WORD_BITS-1]};
    rem_sub   = rem_shift - {1'b0, m_q};
    rem_ge    = (rem_shift >= {1'b0, m_q});
  end

  // Sign rules: removed twos against the modulus mod 8, and reciprocity.
  always_comb begin
    flip_two   = odd_q && ((m_q[2:0] == 3'd3) || (m_q[2:0] == 3'd5));
    flip_recip = (a_q[1:0] == 2'b11) && (m_q[1:0] == 2'b11);
  end

  // Next-state logic of the operand registers.
  always_comb begin
    a_d    = a_q;
    m_d    = m_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    odd_d  = odd_q;
    neg_d  = neg_q;
    even_d = even_q;
    if (cmd_i.load) begin
      a_d    = req_i.numerator[WORD_BITS-1:0];
      m_d    = req_i.modulus[WORD_BITS-1:0];
      dvd_d  = req_i.numerator[WORD_BITS-1:0];
      rem_d  = '0;
      cnt_d  = '0;
      odd_d  = 1'b0;
      neg_d  = 1'b0;
      even_d = ~req_i.modulus[0];
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_sub : rem_shift;
      dvd_d = {dvd_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.div_done) begin
      a_d   = rem_q[WORD_BITS-1:0];
      odd_d = 1'b0;
    end else if (cmd_i.strip_shift) begin
      a_d   = {1'b0, a_q[WORD_BITS-1:1]};
      odd_d = ~odd_q;
    end else if (cmd_i.strip_end) begin
      if (sts_o.a_one) begin
        neg_d = neg_q ^ flip_two;
      end else begin
        // Swap the pair and reduce the old modulus by the numerator.
        neg_d = neg_q ^ flip_two ^ flip_recip;
        m_d   = a_q;
        dvd_d = m_q;
        rem_d = '0;
        cnt_d = '0;
      end
    end
  end

  // Control flags are reset; the operand registers are loaded before use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q  <= 1'b0;
      neg_q  <= 1'b0;
      even_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      odd_q  <= odd_d;
      neg_q  <= neg_d;
      even_q <= even_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    m_q   <= m_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // Status towards the controller.
  always_comb begin
    sts_o.div_last = (cnt_q == CntLast);
    sts_o.a_zero   = (a_q == '0);
    sts_o.a_even   = ~a_q[0];
    sts_o.a_one    = (a_q == WORD_BITS'(1));
  end

  // Result: zero on an even modulus or a common factor, otherwise the sign.
  always_comb begin
    rsp_o.even_modulus = even_q;
    if (even_q || sts_o.a_zero) begin
      rsp_o.symbol = 2'sb00;
    end else if (neg_q) begin
      rsp_o.symbol = 2'sb11;
    end else begin
      rsp_o.symbol = 2'sb01;
    end
  end

endmodule : jsw_datapath

`default_nettype wire

FILE: src/jsw_ctrl.sv
// Controller of the Jacobi symbol word unit: sequences reduction, removal of
// twos and reciprocity steps over the datapath. Depends on jsw_pkg.
`default_nettype none

module jsw_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire               modulus_odd_i,
  input  jsw_pkg::jsw_sts_t sts_i,
  output jsw_pkg::jsw_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import jsw_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StStrip = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  // A new transaction may start while the previous result is shown.
  assign busy_o = (state_q != StIdle) && (state_q != StDone);
  assign done_o = (state_q == StDone);
  assign accept = start_i && !busy_o;

  // State transitions and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle, StDone: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = modulus_odd_i ? StDiv : StDone;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        // The remainder has been computed; a zero one ends with symbol zero.
        cmd_o.div_done = 1'b1;
        state_d        = StStrip;
      end
      StStrip: begin
        if (sts_i.a_zero) begin
          state_d = StDone;
        end else if (sts_i.a_even) begin
          cmd_o.strip_shift = 1'b1;
        end else begin
          cmd_o.strip_end = 1'b1;
          state_d         = sts_i.a_one ? StDone : StDiv;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : jsw_ctrl

`default_nettype wire

FILE: src/jsw_checker.sv
// Port-level checker for the Jacobi symbol word unit, bound to the top level.
// Depends on jsw_pkg and jacobi_symbol_word_unit.
`default_nettype none

module jsw_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start,
  input wire               busy,
  input wire               done_o,
  input jsw_pkg::jsw_rsp_t rsp_o
);
  import jsw_pkg::*;

  // A result is never shown while the unit reports itself busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction either starts work or finishes at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction was dropped");

  // Work only ends by delivering a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  // An even modulus always gives a zero symbol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.even_modulus) |-> (rsp_o.symbol == 2'sb00))
    else $error("nonzero symbol with even modulus");

  // The symbol is never the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.symbol != 2'sb10))
    else $error("invalid symbol code");

endmodule : jsw_checker

bind jacobi_symbol_word_unit jsw_checker u_jsw_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
